// ===== rtl/core/pts_pkg.sv =====
// Package for the per-host TCP traffic statistics block.
// Holds the command, result and counter row types and the status codes.
// No dependencies.
`default_nettype none
package pts_pkg;

    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TCP_SLOT_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TCP_SLOT_INDEX = 1'd1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic FUNC_ACCOUNT = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic        syn_flag;
        logic        ack_flag;
        logic        fin_flag;
        logic [15:0] packet_length;
        logic [31:0] query_ip;
        logic [3:0]  query_slot;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] send_bytes;
        logic [63:0] recv_bytes;
        logic [31:0] send_packets;
        logic [31:0] new_connections;
        logic [31:0] open_connections;
    } result_t;

    typedef struct packed {
        logic [63:0] sent_bytes;
        logic [63:0] recv_bytes;
        logic [31:0] sent_packets;
        logic [31:0] new_conns;
        logic [31:0] open_conns;
    } cnt_row_t;

    typedef struct packed {
        logic        sender;
        logic        conn;
        logic        close;
        logic [15:0] len;
    } charge_t;

endpackage
`default_nettype wire

// ===== rtl/core/pts_key_table.sv =====
// Address key memory with per-entry valid flags.
// Key and valid flag are read at one address per cycle with registered data.
// Depends on nothing but its parameter.
`default_nettype none
module pts_key_table #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
    output logic [31:0]                           rd_key,
    output logic                                  rd_valid,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
    input  wire logic [31:0]                      wr_key
);
    logic [31:0] key_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [31:0] rd_key_reg;
    logic rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_key = rd_key_reg;
    assign rd_valid = rd_valid_reg;
endmodule
`default_nettype wire

// ===== rtl/core/pts_cnt_mem.sv =====
// Counter memory, one row of all counters per entry and protocol slot.
// Uses pts_pkg for the row type; one write and one registered read per cycle.
`default_nettype none
module pts_cnt_mem #(
    parameter int CELLS = 4096
) (
    input  wire logic                     clk,
    input  wire logic [$clog2(CELLS)-1:0] addr,
    input  wire logic                     wr_en,
    input  wire pts_pkg::cnt_row_t        wr_data,
    output pts_pkg::cnt_row_t             rd_data
);
    pts_pkg::cnt_row_t mem [CELLS];
    pts_pkg::cnt_row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// ===== rtl/core/pts_charge_unit.sv =====
// Shared update unit that applies one charge to a counter row.
// Uses pts_pkg for the row and charge types.
`default_nettype none
module pts_charge_unit (
    input  wire pts_pkg::cnt_row_t row_in,
    input  wire pts_pkg::charge_t  chg,
    output pts_pkg::cnt_row_t      row_out
);
    logic [31:0] open_inc;

    always_comb
    begin
        row_out = row_in;
        open_inc = row_in.open_conns + {31'd0, chg.conn};
        if (chg.sender)
        begin
            row_out.sent_bytes = row_in.sent_bytes + {48'd0, chg.len};
            row_out.sent_packets = row_in.sent_packets + 32'd1;
        end
        else
        begin
            row_out.recv_bytes = row_in.recv_bytes + {48'd0, chg.len};
        end
        if (chg.conn)
        begin
            row_out.new_conns = row_in.new_conns + 32'd1;
        end
        if (chg.sender && chg.close && (open_inc != 32'd0))
        begin
            row_out.open_conns = open_inc - 32'd1;
        end
        else
        begin
            row_out.open_conns = open_inc;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/per_ip_tcp_traffic_stats.sv =====
// Per-host TCP traffic statistics table, top level with the sequencer.
// Uses pts_pkg, pts_key_table, pts_cnt_mem and pts_charge_unit.
//
// A command word is taken at a clock edge where start is high and busy is
// low. An account word charges one packet to its source and destination
// addresses; a read word returns the counters of one address and slot.
// Exactly one result word follows each command, shown on result with done
// high for one cycle; the receiver cannot stall it.
// Every command first scans the key table, one entry per cycle, which
// finds both addresses and the two lowest free entries. Each newly
// allocated entry then clears its PROTO_SLOTS counter rows, one per cycle.
// Four counter updates follow, each a read and then a write of the counter
// memory; an update that is skipped does no write. A read command reads
// its counter row and returns it. Busy stays high from the accepting edge
// to the edge that shows the result.
// Reset empties the table and sets the configuration registers to their
// defaults.
`default_nettype none
module per_ip_tcp_traffic_stats #(
    parameter int TABLE_ENTRIES = 256,
    parameter int PROTO_SLOTS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire pts_pkg::cmd_t                      cmd,
    output logic                                    done,
    output pts_pkg::result_t                        result,
    input  wire logic                               cfg_wr_en,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int SW = $clog2(PROTO_SLOTS);
    localparam int CELLS = TABLE_ENTRIES * PROTO_SLOTS;
    localparam int CW = $clog2(CELLS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_CH_RD = 3'd4;
    localparam logic [2:0] S_CH_WR = 3'd5;
    localparam logic [2:0] S_Q_RD = 3'd6;
    localparam logic [2:0] S_Q_OUT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic tcp_en_reg;
    logic [3:0] tcp_idx_reg;
    pts_pkg::cmd_t cmd_reg;

    logic [IW:0] scan_idx_reg, scan_idx_next;
    logic pipe_vld_reg, pipe_vld_next;
    logic [IW-1:0] pipe_idx_reg, pipe_idx_next;
    logic a_found_reg, a_found_next, b_found_reg, b_found_next;
    logic f1_found_reg, f1_found_next, f2_found_reg, f2_found_next;
    logic [IW-1:0] a_idx_reg, a_idx_next, b_idx_reg, b_idx_next;
    logic [IW-1:0] f1_idx_reg, f1_idx_next, f2_idx_reg, f2_idx_next;
    logic need_a_reg, need_a_next, need_b_reg, need_b_next;
    logic [SW-1:0] alloc_slot_reg, alloc_slot_next;
    logic [1:0] op_reg, op_next;
    logic done_reg, done_next;
    pts_pkg::result_t result_reg, result_next;

    logic [31:0] key_a, key_b;
    logic [IW-1:0] key_rd_addr, key_wr_addr;
    logic [31:0] key_rd_key, key_wr_key;
    logic key_rd_valid, key_wr_en;

    logic [CW-1:0] cnt_addr;
    logic cnt_wr_en;
    pts_pkg::cnt_row_t cnt_wr_data, cnt_rd_data, charged_row;
    pts_pkg::charge_t chg;

    logic need_a, need_b, full;
    logic [IW-1:0] op_entry, alloc_entry;
    logic [31:0] op_slot;
    logic op_active, tcp_in_range;

    pts_key_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_keys (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (key_rd_addr),
        .rd_key   (key_rd_key),
        .rd_valid (key_rd_valid),
        .wr_en    (key_wr_en),
        .wr_addr  (key_wr_addr),
        .wr_key   (key_wr_key)
    );

    pts_cnt_mem #(.CELLS(CELLS)) u_cnt (
        .clk     (clk),
        .addr    (cnt_addr),
        .wr_en   (cnt_wr_en),
        .wr_data (cnt_wr_data),
        .rd_data (cnt_rd_data)
    );

    pts_charge_unit u_charge (
        .row_in  (cnt_rd_data),
        .chg     (chg),
        .row_out (charged_row)
    );

    assign key_a = (cmd_reg.func == pts_pkg::FUNC_READ) ? cmd_reg.query_ip : cmd_reg.src_ip;
    assign key_b = cmd_reg.dst_ip;
    assign key_rd_addr = scan_idx_reg[IW-1:0];

    assign need_a = (cmd_reg.src_ip != 32'd0) && !a_found_reg;
    assign need_b = (cmd_reg.dst_ip != 32'd0) && !b_found_reg
        && (cmd_reg.dst_ip != cmd_reg.src_ip);
    assign full = ((need_a || need_b) && !f1_found_reg) || (need_a && need_b && !f2_found_reg);

    assign alloc_entry = need_a_reg ? a_idx_reg : b_idx_reg;
    assign key_wr_en = (state_reg == S_ALLOC) && (need_a_reg || need_b_reg)
        && (alloc_slot_reg == '0);
    assign key_wr_addr = alloc_entry;
    assign key_wr_key = need_a_reg ? cmd_reg.src_ip : cmd_reg.dst_ip;

    assign tcp_in_range = ({28'd0, tcp_idx_reg} < 32'(PROTO_SLOTS));
    assign op_entry = op_reg[0] ? b_idx_reg : a_idx_reg;
    assign op_slot = op_reg[1] ? {28'd0, tcp_idx_reg} : 32'd0;
    assign op_active = (op_reg[0] ? (cmd_reg.dst_ip != 32'd0) : (cmd_reg.src_ip != 32'd0))
        && (!op_reg[1] || (tcp_en_reg && tcp_in_range));

    assign chg.sender = !op_reg[0];
    assign chg.conn = cmd_reg.syn_flag && cmd_reg.ack_flag;
    assign chg.close = cmd_reg.fin_flag && cmd_reg.ack_flag;
    assign chg.len = cmd_reg.packet_length;

    always_comb
    begin
        case (state_reg)
            S_ALLOC:
            begin
                cnt_addr = CW'(32'(alloc_entry) * 32'(PROTO_SLOTS) + 32'(alloc_slot_reg));
            end
            S_Q_RD, S_Q_OUT:
            begin
                cnt_addr = CW'(32'(a_idx_reg) * 32'(PROTO_SLOTS) + {28'd0, cmd_reg.query_slot});
            end
            default:
            begin
                cnt_addr = CW'(32'(op_entry) * 32'(PROTO_SLOTS) + op_slot);
            end
        endcase
    end

    assign cnt_wr_en = ((state_reg == S_ALLOC) && (need_a_reg || need_b_reg))
        || (state_reg == S_CH_WR);
    assign cnt_wr_data = (state_reg == S_CH_WR) ? charged_row : '0;

    always_comb
    begin
        state_next = state_reg;
        scan_idx_next = scan_idx_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = pipe_idx_reg;
        a_found_next = a_found_reg;
        b_found_next = b_found_reg;
        f1_found_next = f1_found_reg;
        f2_found_next = f2_found_reg;
        a_idx_next = a_idx_reg;
        b_idx_next = b_idx_reg;
        f1_idx_next = f1_idx_reg;
        f2_idx_next = f2_idx_reg;
        need_a_next = need_a_reg;
        need_b_next = need_b_reg;
        alloc_slot_next = alloc_slot_reg;
        op_next = op_reg;
        done_next = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    scan_idx_next = '0;
                    a_found_next = 1'b0;
                    b_found_next = 1'b0;
                    f1_found_next = 1'b0;
                    f2_found_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg != (IW + 1)'(TABLE_ENTRIES))
                begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
                if (pipe_vld_reg)
                begin
                    if (key_rd_valid)
                    begin
                        if (!a_found_reg && (key_rd_key == key_a) && (key_a != 32'd0))
                        begin
                            a_found_next = 1'b1;
                            a_idx_next = pipe_idx_reg;
                        end
                        if (!b_found_reg && (key_rd_key == key_b) && (key_b != 32'd0))
                        begin
                            b_found_next = 1'b1;
                            b_idx_next = pipe_idx_reg;
                        end
                    end
                    else if (!f1_found_reg)
                    begin
                        f1_found_next = 1'b1;
                        f1_idx_next = pipe_idx_reg;
                    end
                    else if (!f2_found_reg)
                    begin
                        f2_found_next = 1'b1;
                        f2_idx_next = pipe_idx_reg;
                    end
                end
            end
            S_DECIDE:
            begin
                result_next = '0;
                if (cmd_reg.func == pts_pkg::FUNC_READ)
                begin
                    if (!a_found_reg)
                    begin
                        result_next.status = pts_pkg::STATUS_NOT_FOUND;
                        done_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if ({28'd0, cmd_reg.query_slot} < 32'(PROTO_SLOTS))
                    begin
                        state_next = S_Q_RD;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (full)
                begin
                    result_next.status = pts_pkg::STATUS_FULL;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    need_a_next = need_a;
                    need_b_next = need_b;
                    alloc_slot_next = '0;
                    op_next = '0;
                    if (need_a)
                    begin
                        a_idx_next = f1_idx_reg;
                    end
                    if (need_b)
                    begin
                        b_idx_next = need_a ? f2_idx_reg : f1_idx_reg;
                    end
                    else if ((cmd_reg.dst_ip == cmd_reg.src_ip) && (cmd_reg.dst_ip != 32'd0))
                    begin
                        b_idx_next = need_a ? f1_idx_reg : a_idx_reg;
                    end
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (need_a_reg || need_b_reg)
                begin
                    if (alloc_slot_reg == SW'(PROTO_SLOTS - 1))
                    begin
                        alloc_slot_next = '0;
                        if (need_a_reg)
                        begin
                            need_a_next = 1'b0;
                        end
                        else
                        begin
                            need_b_next = 1'b0;
                        end
                    end
                    else
                    begin
                        alloc_slot_next = alloc_slot_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = S_CH_RD;
                end
            end
            S_CH_RD:
            begin
                if (op_active)
                begin
                    state_next = S_CH_WR;
                end
                else if (op_reg == 2'd3)
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    op_next = op_reg + 2'd1;
                end
            end
            S_CH_WR:
            begin
                if (op_reg == 2'd3)
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    op_next = op_reg + 2'd1;
                    state_next = S_CH_RD;
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_OUT;
            end
            S_Q_OUT:
            begin
                result_next.status = pts_pkg::STATUS_OK;
                result_next.send_bytes = cnt_rd_data.sent_bytes;
                result_next.recv_bytes = cnt_rd_data.recv_bytes;
                result_next.send_packets = cnt_rd_data.sent_packets;
                result_next.new_connections = cnt_rd_data.new_conns;
                result_next.open_connections = cnt_rd_data.open_conns;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tcp_en_reg <= 1'b0;
            tcp_idx_reg <= 4'd1;
            scan_idx_reg <= '0;
            pipe_vld_reg <= 1'b0;
            a_found_reg <= 1'b0;
            b_found_reg <= 1'b0;
            f1_found_reg <= 1'b0;
            f2_found_reg <= 1'b0;
            need_a_reg <= 1'b0;
            need_b_reg <= 1'b0;
            alloc_slot_reg <= '0;
            op_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    pts_pkg::REG_TCP_SLOT_ENABLE:
                    begin
                        tcp_en_reg <= cfg_data[0];
                    end
                    pts_pkg::REG_TCP_SLOT_INDEX:
                    begin
                        tcp_idx_reg <= cfg_data[3:0];
                    end
                    default:
                    begin
                        tcp_en_reg <= tcp_en_reg;
                    end
                endcase
            end
            scan_idx_reg <= scan_idx_next;
            pipe_vld_reg <= pipe_vld_next;
            a_found_reg <= a_found_next;
            b_found_reg <= b_found_next;
            f1_found_reg <= f1_found_next;
            f2_found_reg <= f2_found_next;
            need_a_reg <= need_a_next;
            need_b_reg <= need_b_next;
            alloc_slot_reg <= alloc_slot_next;
            op_reg <= op_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            cmd_reg <= cmd;
        end
        pipe_idx_reg <= pipe_idx_next;
        a_idx_reg <= a_idx_next;
        b_idx_reg <= b_idx_next;
        f1_idx_reg <= f1_idx_next;
        f2_idx_reg <= f2_idx_next;
        result_reg <= result_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result = result_reg;
endmodule
`default_nettype wire
